>>> hw/rtl/nsq_pkg.sv
// shared types and constants of the nearest segment query block
package nsq_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] CFG_LINE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_SQ = 2'd1;

    localparam int T_FRAC = 16;
    localparam logic [47:0] THRESHOLD_RESET = 48'd262144;

    typedef struct packed {
        logic wr;
        logic start;
        logic rd;
        logic load;
        logic mul;
        logic sum;
        logic clamp;
        logic div;
        logic err;
        logic rnd;
        logic sq;
        logic cmp;
        logic next;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic zero;
        logic dot_le0;
        logic dot_ge;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/nearest_segment_query.sv
// top level of the nearest segment query block
// usage:
// - input channel (i_valid / o_stall) carries one transaction per item; action 0 stores
//   a segment at i_entry, action 1 queries the point i_point_x / i_point_y
// - a segment write does not stall the input and gives no result
// - a query walks entries 0 .. min(line_count, MAX_SEGMENTS)-1 through a shared
//   multi-cycle distance unit; a zero-length entry is skipped after its load, and the
//   16-step divide for t runs only when t does not clamp to 0 or 1
// - o_stall stays high for the whole query; one query is in work at a time
// - the result leaves through an output register (o_valid / i_stall); a new item is
//   taken while that result waits, and a finished query holds until the register frees
// - config port (i_cfg_valid / o_cfg_ready) is always ready; index 0 line_count,
//   index 1 threshold_sq, other indexes are ignored
// - synchronous active-low reset clears the sequencer, output valid, line_count to 0
//   and threshold_sq to 262144; the segment table is not cleared
module nearest_segment_query #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic [7:0]                    i_entry,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [7:0]                    o_nearest_index,
    output logic [47:0]                   o_distance_sq,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [47:0]                   i_cfg_data
);

    nsq_pkg::t_cmd    cmd;
    nsq_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    nsq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nsq_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry         (i_entry),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_nearest_index (o_nearest_index),
        .o_distance_sq   (o_distance_sq)
    );

`ifndef SYNTH
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_nearest_index == 8'd0 && o_distance_sq == 48'd0))
        else $error("not-found result carries nonzero fields");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == nsq_pkg::ACT_QUERY) |=> o_stall)
        else $error("query transaction did not hold off input");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == nsq_pkg::ACT_WRITE) |=> !o_stall)
        else $error("write transaction left input stalled");
`endif

endmodule

>>> hw/rtl/nsq_ctrl.sv
// sequencer that issues segment writes and walks the segment table for one query at a time
module nsq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    output logic             o_stall,
    input  nsq_pkg::t_status i_status,
    output nsq_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_CLAMP = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_RND   = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_READ  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_action == nsq_pkg::ACT_WRITE) begin
                    o_cmd.wr = 1'b1;
                end
                if (accept && i_action == nsq_pkg::ACT_QUERY) begin
                    o_cmd.start = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.more) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (i_status.zero) begin
                    o_cmd.next = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_step = '0;
                if (i_status.dot_le0 || i_status.dot_ge) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = S_CHECK;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

>>> hw/rtl/nsq_dp.sv
// segment table, config registers, distance arithmetic, best tracking and result register
module nsq_dp #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsq_pkg::t_cmd                 i_cmd,
    output nsq_pkg::t_status              o_status,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [47:0]                   i_cfg_data,
    input  logic [7:0]                    i_entry,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [7:0]                    o_nearest_index,
    output logic [47:0]                   o_distance_sq
);

    localparam int W   = COORD_WIDTH;
    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int TW  = nsq_pkg::T_FRAC + 1;
    localparam int MW  = DW + TW + 1;
    localparam int EW  = DW + 19;
    localparam int XW  = EW - 16;
    localparam int QW  = 2 * XW;
    localparam int DSW = QW + 1;

    logic [4*W-1:0] r_mem [MAX_SEGMENTS];
    logic [4*W-1:0] r_rd;

    logic [8:0]  r_line_count;
    logic [47:0] r_threshold;

    logic signed [W-1:0]  r_px, r_py;
    logic [CW-1:0]        r_idx;
    logic signed [DW-1:0] r_dx, r_dy, r_wx, r_wy;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0] r_len, r_dot;
    logic [SW-1:0]        r_rem;
    logic [TW-1:0]        r_t;
    logic signed [MW-1:0] r_tx, r_ty;
    logic signed [XW-1:0] r_ex, r_ey;
    logic signed [QW-1:0] r_sx, r_sy;
    logic                 r_found;
    logic [47:0]          r_best;
    logic [CW-1:0]        r_best_idx;

    logic                 r_out_valid;
    logic                 r_out_found;
    logic [7:0]           r_out_idx;
    logic [47:0]          r_out_dist;

    logic [12:0]          ent_ext;
    logic [12:0]          idx_ext;
    logic                 wr_ok;
    logic [SW-1:0]        shifted;
    logic signed [EW-1:0] e_x, e_y;
    logic [DSW-1:0]       cur_dist;
    logic                 better;

    assign ent_ext = 13'(i_entry);
    assign idx_ext = 13'(r_idx);
    assign wr_ok   = ent_ext < 13'(MAX_SEGMENTS);

    assign o_status.more     = (idx_ext < 13'(r_line_count)) && (idx_ext < 13'(MAX_SEGMENTS));
    assign o_status.zero     = (r_dx == '0) && (r_dy == '0);
    assign o_status.dot_le0  = (r_dot <= 0);
    assign o_status.dot_ge   = (r_dot >= r_len);
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign shifted  = {r_rem[SW-2:0], 1'b0};
    assign e_x      = (EW'(r_wx) <<< nsq_pkg::T_FRAC) - EW'(r_tx);
    assign e_y      = (EW'(r_wy) <<< nsq_pkg::T_FRAC) - EW'(r_ty);
    assign cur_dist = DSW'($unsigned(r_sx)) + DSW'($unsigned(r_sy));
    assign better   = (cur_dist <= DSW'(r_threshold)) && (!r_found || cur_dist < DSW'(r_best));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            r_mem[ent_ext[AW-1:0]] <= {i_start_x, i_start_y, i_end_x, i_end_y};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_threshold  <= nsq_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == nsq_pkg::CFG_LINE_COUNT) begin
                r_line_count <= i_cfg_data[8:0];
            end
            if (i_cfg_index == nsq_pkg::CFG_THRESHOLD_SQ) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (i_cmd.load) begin
            r_dx <= DW'($signed(r_rd[2*W-1:W])) - DW'($signed(r_rd[4*W-1:3*W]));
            r_dy <= DW'($signed(r_rd[W-1:0])) - DW'($signed(r_rd[3*W-1:2*W]));
            r_wx <= DW'(r_px) - DW'($signed(r_rd[4*W-1:3*W]));
            r_wy <= DW'(r_py) - DW'($signed(r_rd[3*W-1:2*W]));
        end
        if (i_cmd.mul) begin
            r_p0 <= r_dx * r_dx;
            r_p1 <= r_dy * r_dy;
            r_p2 <= r_wx * r_dx;
            r_p3 <= r_wy * r_dy;
        end
        if (i_cmd.sum) begin
            r_len <= SW'(r_p0) + SW'(r_p1);
            r_dot <= SW'(r_p2) + SW'(r_p3);
        end
        if (i_cmd.clamp) begin
            r_rem <= $unsigned(r_dot);
            if (r_dot <= 0) begin
                r_t <= '0;
            end else if (r_dot >= r_len) begin
                r_t <= TW'(1) << nsq_pkg::T_FRAC;
            end else begin
                r_t <= '0;
            end
        end
        if (i_cmd.div) begin
            if (shifted >= $unsigned(r_len)) begin
                r_rem <= shifted - $unsigned(r_len);
                r_t   <= {r_t[TW-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_t   <= {r_t[TW-2:0], 1'b0};
            end
        end
        if (i_cmd.err) begin
            r_tx <= MW'($signed({1'b0, r_t})) * MW'(r_dx);
            r_ty <= MW'($signed({1'b0, r_t})) * MW'(r_dy);
        end
        if (i_cmd.rnd) begin
            r_ex <= XW'((e_x + EW'(32768)) >>> nsq_pkg::T_FRAC);
            r_ey <= XW'((e_y + EW'(32768)) >>> nsq_pkg::T_FRAC);
        end
        if (i_cmd.sq) begin
            r_sx <= r_ex * r_ex;
            r_sy <= r_ey * r_ey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.next || i_cmd.cmp) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.cmp && better) begin
                r_found    <= 1'b1;
                r_best     <= cur_dist[47:0];
                r_best_idx <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
            r_out_found <= r_found;
            r_out_idx   <= r_found ? 8'(r_best_idx) : 8'd0;
            r_out_dist  <= r_found ? r_best : 48'd0;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_nearest_index = r_out_idx;
    assign o_distance_sq   = r_out_dist;

endmodule

>>> tb/testbench.sv
// self-checking testbench for the nearest segment query block
`timescale 1ns / 100ps

module testbench;

    localparam int CW = 24;
    localparam int SEGS = 256;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int IDLE_WAIT = 40;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam logic signed [CW-1:0] C_MIN = -(24'sd1 <<< (CW-1));
    localparam logic signed [CW-1:0] C_MAX = (24'sd1 <<< (CW-1)) - 1;

    typedef struct {
        logic                 action;
        logic [7:0]           entry;
        logic signed [CW-1:0] sx, sy, ex, ey, px, py;
    } t_seg_item;

    typedef struct {
        logic        found;
        logic [7:0]  index;
        logic [47:0] dist_sq;
    } t_hit;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_action = 0, i_stall = 0;
    logic [7:0] i_entry = 0;
    logic signed [CW-1:0] i_start_x = 0, i_start_y = 0, i_end_x = 0, i_end_y = 0;
    logic signed [CW-1:0] i_point_x = 0, i_point_y = 0;
    logic i_cfg_valid = 0;
    logic [1:0] i_cfg_index = 0;
    logic [47:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_found, o_cfg_ready;
    logic [7:0] o_nearest_index;
    logic [47:0] o_distance_sq;

    nearest_segment_query DUT (.*);

    // predictor state
    logic signed [CW-1:0] tbl_sx[SEGS], tbl_sy[SEGS], tbl_ex[SEGS], tbl_ey[SEGS];
    bit tbl_written[SEGS];
    logic [8:0] pred_count = 0;
    logic [47:0] pred_thresh = nsq_pkg::THRESHOLD_RESET;
    t_hit pending_hits[$];
    int errors = 0;
    longint cycles = 0;
    int burst_left = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern
    int stall_mode = 0, stall_run = 0;
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(10, 80);
        end
        stall_run--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= 1'($urandom_range(0, 1));
            2: i_stall <= ($urandom_range(0, 7) != 0);
            default: i_stall <= ~i_stall;
        endcase
    end

    function automatic t_hit nearest_hit(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
        t_hit h;
        int lim;
        longint dx, dy, wx, wy, len, dot, t, rem, exr, eyr, d;
        h.found = 0; h.index = 0; h.dist_sq = 0;
        lim = (pred_count > SEGS) ? SEGS : pred_count;
        for (int i = 0; i < lim; i++) begin
            dx = longint'(tbl_ex[i]) - longint'(tbl_sx[i]);
            dy = longint'(tbl_ey[i]) - longint'(tbl_sy[i]);
            if (dx == 0 && dy == 0) continue;
            wx = longint'(px) - longint'(tbl_sx[i]);
            wy = longint'(py) - longint'(tbl_sy[i]);
            len = dx * dx + dy * dy;
            dot = wx * dx + wy * dy;
            if (dot <= 0) t = 0;
            else if (dot >= len) t = 65536;
            else begin
                rem = dot; t = 0;
                for (int k = 0; k < nsq_pkg::T_FRAC; k++) begin
                    rem = rem <<< 1;
                    t = t <<< 1;
                    if (rem >= len) begin
                        rem -= len;
                        t |= 1;
                    end
                end
            end
            exr = (wx * 65536 - t * dx + 32768) >>> 16;
            eyr = (wy * 65536 - t * dy + 32768) >>> 16;
            d = exr * exr + eyr * eyr;
            if (d <= longint'({16'd0, pred_thresh}) && (!h.found || d < longint'(h.dist_sq)))
            begin
                h.found = 1;
                h.index = i[7:0];
                h.dist_sq = d[47:0];
            end
        end
        return h;
    endfunction

    always @(posedge i_clk) begin
        t_hit want;
        if (o_valid && !i_stall) begin
            if (pending_hits.size() == 0) begin
                $error("result with no query waiting");
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (o_found !== want.found) begin
                    $error("found expected %0d actual %0d", want.found, o_found);
                    errors++;
                end
                if (o_nearest_index !== want.index) begin
                    $error("nearest_index expected %0d actual %0d", want.index,
                           o_nearest_index);
                    errors++;
                end
                if (o_distance_sq !== want.dist_sq) begin
                    $error("distance_sq expected %0d actual %0d", want.dist_sq,
                           o_distance_sq);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(t_seg_item it);
        int gap;
        @(negedge i_clk);
        i_valid <= 1;
        i_action <= it.action;
        i_entry <= it.entry;
        i_start_x <= it.sx; i_start_y <= it.sy;
        i_end_x <= it.ex; i_end_y <= it.ey;
        i_point_x <= it.px; i_point_y <= it.py;
        do @(posedge i_clk); while (o_stall);
        if (it.action == nsq_pkg::ACT_WRITE) begin
            tbl_sx[it.entry] = it.sx; tbl_sy[it.entry] = it.sy;
            tbl_ex[it.entry] = it.ex; tbl_ey[it.entry] = it.ey;
            tbl_written[it.entry] = 1;
        end else begin
            pending_hits.push_back(nearest_hit(it.px, it.py));
        end
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_and_idle();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        drain_and_idle();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == nsq_pkg::CFG_LINE_COUNT) pred_count = val[8:0];
        else if (idx == nsq_pkg::CFG_THRESHOLD_SQ) pred_thresh = val;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < SEGS && tbl_written[n]) n++;
        return n;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(bit full);
        logic [31:0] r;
        r = $urandom;
        if (full) return r[CW-1:0];
        return CW'($signed(r[11:0]));
    endfunction

    function automatic t_seg_item mk_write(int e, logic signed [CW-1:0] sx, sy, ex, ey);
        t_seg_item it;
        it.action = nsq_pkg::ACT_WRITE; it.entry = e[7:0];
        it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
        it.px = rand_coord(1); it.py = rand_coord(1);
        return it;
    endfunction

    function automatic t_seg_item mk_query(logic signed [CW-1:0] px, py);
        t_seg_item it;
        it.action = nsq_pkg::ACT_QUERY; it.entry = 8'($urandom);
        it.sx = rand_coord(1); it.sy = rand_coord(1);
        it.ex = rand_coord(1); it.ey = rand_coord(1);
        it.px = px; it.py = py;
        return it;
    endfunction

    function automatic t_seg_item rand_item(int wr_pct, int max_entry);
        bit full;
        full = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < wr_pct)
            return mk_write($urandom_range(0, max_entry), rand_coord(full), rand_coord(full),
                            rand_coord(full), rand_coord(full));
        return mk_query(rand_coord(full), rand_coord(full));
    endfunction

    task automatic test_directed();
        send_item(mk_write(0, C_MIN, C_MIN, C_MAX, C_MAX));
        send_item(mk_write(1, 24'sd1280, 24'sd1280, 24'sd1280, 24'sd1280));
        send_item(mk_write(2, 24'sd0, 24'sd0, 24'sd1024, 24'sd0));
        send_item(mk_write(3, 24'sd0, 24'sd0, 24'sd1024, 24'sd0));
        send_item(mk_write(4, C_MAX, C_MIN, C_MIN, C_MAX));
        send_item(mk_write(5, -24'sd300, 24'sd77, 24'sd513, -24'sd999));
        write_reg(nsq_pkg::CFG_LINE_COUNT, 48'd6);
        write_reg(nsq_pkg::CFG_THRESHOLD_SQ, 48'hFFFF_FFFF_FFFF);
        send_item(mk_query(24'sd500, 24'sd100));
        send_item(mk_query(24'sd2000, -24'sd50));
        send_item(mk_query(-24'sd700, 24'sd3));
        send_item(mk_query(C_MIN, C_MAX));
        send_item(mk_query(C_MAX, C_MIN));
        send_item(mk_query(24'sd1280, 24'sd1280));
        write_reg(nsq_pkg::CFG_THRESHOLD_SQ, 48'd0);
        send_item(mk_query(24'sd512, 24'sd0));
        send_item(mk_query(24'sd512, 24'sd9000));
        write_reg(nsq_pkg::CFG_LINE_COUNT, 48'd0);
        send_item(mk_query(24'sd512, 24'sd0));
        write_reg(CFG_SPARE_A, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_B, 48'd0);
        write_reg(nsq_pkg::CFG_THRESHOLD_SQ, nsq_pkg::THRESHOLD_RESET);
        write_reg(nsq_pkg::CFG_LINE_COUNT, 48'd4);
        send_item(mk_query(24'sd300, 24'sd200));
    endtask

    task automatic test_random(int n_items);
        int cnt;
        logic [47:0] th;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                cnt = written_prefix();
                if (cnt > 16) cnt = 16;
                write_reg(nsq_pkg::CFG_LINE_COUNT, 48'($urandom_range(0, cnt)));
                case ($urandom_range(0, 4))
                    0: th = nsq_pkg::THRESHOLD_RESET;
                    1: th = 48'd0;
                    2: th = 48'hFFFF_FFFF_FFFF;
                    3: th = 48'({$urandom, $urandom});
                    default: th = 48'($urandom_range(0, 1 << 22));
                endcase
                write_reg(nsq_pkg::CFG_THRESHOLD_SQ, th);
            end
            send_item(rand_item(55, ($urandom_range(0, 9) == 0) ? 255 : 15));
        end
    endtask

    task automatic test_full_table();
        for (int e = 0; e < SEGS; e++)
            send_item(mk_write(e, rand_coord(e % 5 == 0), rand_coord(e % 5 == 0),
                               rand_coord(e % 7 == 0), rand_coord(e % 7 == 0)));
        write_reg(nsq_pkg::CFG_THRESHOLD_SQ, 48'hFFFF_FFFF_FFFF);
        write_reg(nsq_pkg::CFG_LINE_COUNT, 48'd256);
        send_item(mk_query(rand_coord(0), rand_coord(0)));
        send_item(mk_query(rand_coord(1), rand_coord(1)));
        write_reg(nsq_pkg::CFG_THRESHOLD_SQ, nsq_pkg::THRESHOLD_RESET);
        write_reg(nsq_pkg::CFG_LINE_COUNT, 48'd511);
        send_item(mk_query(rand_coord(0), rand_coord(0)));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_random(400);
        test_full_table();
        test_random(130);
        drain_and_idle();
        repeat (100) @(negedge i_clk);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
